// ===== hw/rtl/bffa_pkg.sv =====
// Shared types and codes for the bitmap first-fit allocator.
package bffa_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam int SIZE_W  = 10;
    localparam int ADDR_W  = 10;
    localparam int START_W = 10;
    localparam int FREE_W  = 11;

    localparam logic [7:0] WORD_ALL = 8'hFF;
    localparam logic [2:0] BIT_MASK = 3'h7;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [START_W-1:0] start_res;
        logic [FREE_W-1:0]  free_bytes;
    } t_rsp;

endpackage

// ===== hw/rtl/bffa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bffa_engine.sv =====
// Sequencer that clears, scans, marks and frees the used-bit map one word per cycle.
module bffa_engine #(
    parameter int HEAP_SIZE_LOG = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  bffa_pkg::t_req           i_req,
    output logic                     o_idle,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output bffa_pkg::t_rsp           o_rsp,
    output logic                     o_mem_we,
    output logic [HEAP_SIZE_LOG-4:0] o_mem_waddr,
    output logic [7:0]               o_mem_wdata,
    output logic [HEAP_SIZE_LOG-4:0] o_mem_raddr,
    input  logic [7:0]               i_mem_rdata
);
    import bffa_pkg::*;

    localparam int L         = HEAP_SIZE_LOG;
    localparam int HEAP_LEN  = 1 << L;
    localparam int WW        = L - 3;
    localparam int MAP_WORDS = 1 << WW;
    localparam int CW        = L + 1;
    localparam int SW        = ((CW > FREE_W) ? CW : FREE_W) + 1;

    localparam logic [WW-1:0] LAST_WD     = WW'(MAP_WORDS - 1);
    localparam logic [SW-1:0] HEAP_X      = SW'(HEAP_LEN);
    localparam logic [SW-1:0] COUNT_MAX_X = SW'((1 << CW) - 1);
    localparam logic [CW-1:0] COUNT_MAX   = CW'((1 << CW) - 1);
    localparam logic [CW-1:0] FC_RESET    = CW'(HEAP_LEN);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_FREE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [WW-1:0]       r_wd, n_wd;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [2:0]          r_bit, n_bit;
    logic [L:0]          r_run, n_run;
    logic                r_zf, n_zf;
    logic [L-1:0]        r_p, n_p;
    logic [L-1:0]        r_end, n_end;
    logic [CW-1:0]       r_fc, n_fc;
    logic                r_status, n_status;
    logic [START_W-1:0]  r_start, n_start;

    logic [L:0]          sc_run;
    logic                sc_zf;
    logic                sc_found;
    logic [2:0]          sc_bit;
    logic [L-1:0]        sc_pos;
    logic [SW-1:0]       sc_diff;
    logic [L-1:0]        sc_p;
    logic [L-1:0]        sc_end;

    logic [L-1:0]        mk_pos;
    logic [7:0]          mk_mask;
    logic                mk_last;

    logic [7:0]          fr_word;
    logic                fr_go;
    logic [3:0]          fr_cnt;
    logic [L:0]          fr_run;
    logic                fr_more;

    logic [SW-1:0]       fc_x;
    logic [SW-1:0]       sub_x;
    logic [SW-1:0]       free_sum;
    logic [CW-1:0]       alloc_fc;
    logic [CW-1:0]       free_fc;
    logic [SW-1:0]       addr_x;
    logic [SW-1:0]       p_x;
    logic                addr_ok;

    // First-fit step over one map word.
    always_comb begin
        sc_run   = r_run;
        sc_zf    = r_zf;
        sc_found = 1'b0;
        sc_bit   = '0;
        for (int k = 0; k < 8; k++) begin
            if (!sc_found) begin
                if (i_mem_rdata[k]) begin
                    sc_run = '0;
                    sc_zf  = 1'b0;
                end else begin
                    sc_run = sc_run + 1'b1;
                    if (SW'(sc_run) >= SW'(r_size) + (sc_zf ? SW'(1) : SW'(2))) begin
                        sc_found = 1'b1;
                        sc_bit   = 3'(k);
                    end
                end
            end
        end
        sc_pos  = {r_wd, sc_bit};
        sc_diff = SW'(sc_pos) - SW'(r_size);
        sc_p    = sc_diff[L-1:0];
        sc_end  = sc_pos - L'(1);
    end

    // Bits of the current word that fall inside the new allocation.
    always_comb begin
        mk_pos = '0;
        for (int k = 0; k < 8; k++) begin
            mk_pos     = {r_wd, 3'(k)};
            mk_mask[k] = (mk_pos >= r_p) && (mk_pos <= r_end);
        end
        mk_last = (r_wd == r_end[L-1:3]);
    end

    // Clear the run of set bits that starts at the current bit.
    always_comb begin
        fr_word = i_mem_rdata;
        fr_go   = 1'b1;
        fr_cnt  = '0;
        for (int k = 0; k < 8; k++) begin
            if ((3'(k) >= r_bit) && fr_go) begin
                if (fr_word[k]) begin
                    fr_word[k] = 1'b0;
                    fr_cnt     = fr_cnt + 1'b1;
                end else begin
                    fr_go = 1'b0;
                end
            end
        end
        fr_run  = r_run + (L+1)'(fr_cnt);
        fr_more = fr_go && (r_wd != LAST_WD);
    end

    always_comb begin
        fc_x     = SW'(r_fc);
        sub_x    = SW'(r_size) + SW'(1);
        alloc_fc = (fc_x >= sub_x) ? CW'(fc_x - sub_x) : '0;
        free_sum = fc_x + SW'(fr_run) + SW'(1);
        free_fc  = (free_sum > COUNT_MAX_X) ? COUNT_MAX : free_sum[CW-1:0];
        addr_x   = SW'(i_req.address);
        addr_ok  = addr_x < HEAP_X;
        p_x      = SW'(r_p);
    end

    always_comb begin
        n_state     = r_state;
        n_wd        = r_wd;
        n_size      = r_size;
        n_bit       = r_bit;
        n_run       = r_run;
        n_zf        = r_zf;
        n_p         = r_p;
        n_end       = r_end;
        n_fc        = r_fc;
        n_status    = r_status;
        n_start     = r_start;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wd;
        o_mem_wdata = '0;
        o_mem_raddr = r_wd;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                n_wd     = r_wd + 1'b1;
                if (r_wd == LAST_WD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_size   = i_req.size;
                    n_status = ST_OK;
                    n_start  = '0;
                    n_run    = '0;
                    n_zf     = 1'b1;
                    if (i_req.op == OP_ALLOC) begin
                        if (i_req.size == '0) begin
                            n_status = ST_FAIL;
                            n_state  = S_DONE;
                        end else begin
                            o_mem_raddr = '0;
                            n_wd        = '0;
                            n_state     = S_SCAN;
                        end
                    end else if (addr_ok) begin
                        o_mem_raddr = addr_x[L-1:3];
                        n_wd        = addr_x[L-1:3];
                        n_bit       = i_req.address[2:0] & BIT_MASK;
                        n_state     = S_FREE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_mem_raddr = r_wd + 1'b1;
                n_wd        = r_wd + 1'b1;
                n_run       = sc_run;
                n_zf        = sc_zf;
                if (sc_found) begin
                    o_mem_raddr = sc_p[L-1:3];
                    n_wd        = sc_p[L-1:3];
                    n_p         = sc_p;
                    n_end       = sc_end;
                    n_state     = S_MARK;
                end else if (r_wd == LAST_WD) begin
                    n_status = ST_FAIL;
                    n_state  = S_DONE;
                end
            end
            S_MARK: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata | (mk_mask & WORD_ALL);
                if (mk_last) begin
                    n_fc    = alloc_fc;
                    n_start = p_x[START_W-1:0];
                    n_state = S_DONE;
                end else begin
                    o_mem_raddr = r_wd + 1'b1;
                    n_wd        = r_wd + 1'b1;
                end
            end
            S_FREE: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = fr_word;
                n_run       = fr_run;
                if (fr_more) begin
                    o_mem_raddr = r_wd + 1'b1;
                    n_wd        = r_wd + 1'b1;
                    n_bit       = '0;
                end else begin
                    n_fc    = free_fc;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_wd    <= '0;
            r_fc    <= FC_RESET;
        end else begin
            r_state <= n_state;
            r_wd    <= n_wd;
            r_fc    <= n_fc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_bit    <= n_bit;
        r_run    <= n_run;
        r_zf     <= n_zf;
        r_p      <= n_p;
        r_end    <= n_end;
        r_status <= n_status;
        r_start  <= n_start;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp       = '{status: r_status, start_res: r_start, free_bytes: fc_x[FREE_W-1:0]};

    a_mark_sets_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> ((i_mem_rdata & ~o_mem_wdata) == 8'h00))
        else $error("Marking cleared a used bit.");

    a_free_clears_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |-> ((o_mem_wdata & ~i_mem_rdata) == 8'h00))
        else $error("Freeing set a bit.");

    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_p <= r_end))
        else $error("Allocation range is empty.");

    a_alloc_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK && n_state == S_DONE) |=> (r_fc <= $past(r_fc)))
        else $error("Allocation raised the free count.");

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_rsp_ready) |=> (r_state == S_IDLE))
        else $error("Result handoff did not return to idle.");

endmodule

// ===== hw/rtl/bitmap_first_fit_allocator_unit.sv =====
// Top level of the bitmap first-fit heap allocator with its output register.
//
//   Channel   Direction  Valid        Stall        Payload
//   request   in         i_in_valid   o_in_stall   i_in_item  (op, size, address)
//   result    out        o_out_valid  i_out_stall  o_out_item (status, start_res, free_bytes)
//
// After reset a clearing pass writes all 2^(HEAP_SIZE_LOG-3) map words to zero, with no item taken.
// The map memory is read and written one 8-bit word per cycle; that port sets the rate.
// Allocate scans map words until a fit is found, then marks the words of the new block.
// Free clears words while its run lasts; a zero-size allocate or off-heap free skips the map.
// One item is in work at a time; a new one is taken while the last result waits in the output.
module bitmap_first_fit_allocator_unit #(
    parameter int HEAP_SIZE_LOG = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bffa_pkg::t_req i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bffa_pkg::t_rsp o_out_item
);
    import bffa_pkg::*;

    localparam int WW        = HEAP_SIZE_LOG - 3;
    localparam int MAP_WORDS = 1 << WW;

    logic          eng_idle;
    logic          rsp_valid;
    logic          rsp_ready;
    t_rsp          rsp;
    logic          mem_we;
    logic [WW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [WW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic          r_out_valid;
    t_rsp          r_out;

    bffa_ram #(
        .WIDTH(8),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    bffa_engine #(
        .HEAP_SIZE_LOG(HEAP_SIZE_LOG)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_in_valid),
        .i_req      (i_in_item),
        .o_idle     (eng_idle),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp      (rsp),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .o_mem_raddr(mem_raddr),
        .i_mem_rdata(mem_rdata)
    );

    assign rsp_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid && rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid && rsp_ready) begin
            r_out <= rsp;
        end
    end

    assign o_in_stall  = !eng_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== test/tb_bitmap_first_fit_allocator_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap first-fit allocator unit with a bit-level heap model.
module tb_bitmap_first_fit_allocator_unit;
    import bffa_pkg::*;

    localparam int HEAP_BYTES   = 1024;
    localparam int COUNT_TOP    = 2047;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_case;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_item;

    bit [HEAP_BYTES-1:0] heap_used;
    int unsigned         heap_free;
    t_rsp                rsp_owed_q[$];
    int unsigned         live_q[$];
    t_case               dir_q[$];
    int                  fail_count   = 0;
    int                  results_seen = 0;
    int                  idle_phase   = 0;
    int                  cycle_count  = 0;
    int                  hold_cycles  = 0;
    bit                  hold_done    = 1'b0;

    bitmap_first_fit_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic bit first_fit(input int unsigned n, output int unsigned p);
        int unsigned run;
        run = 0;
        p = 0;
        for (int i = 0; i < HEAP_BYTES; i++) begin
            if (heap_used[i]) begin
                run = 0;
            end else begin
                run++;
                if (run >= n + 2 || (run >= n + 1 && run == i + 1)) begin
                    p = i - n;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic heap_apply(input t_req r, output t_rsp rsp);
        int unsigned p;
        int unsigned run;
        int unsigned k;
        rsp = '0;
        rsp.status = ST_OK;
        if (r.op == OP_ALLOC) begin
            if (r.size == 0 || !first_fit(32'(r.size), p)) begin
                rsp.status = ST_FAIL;
            end else begin
                for (k = p; k < p + r.size; k++) heap_used[k] = 1'b1;
                heap_used[p + r.size] = 1'b0;
                heap_free = (heap_free >= r.size + 1) ? heap_free - r.size - 1 : 0;
                rsp.start_res = START_W'(p);
            end
        end else begin
            run = 0;
            k = 32'(r.address);
            while (k < HEAP_BYTES && heap_used[k]) begin
                heap_used[k] = 1'b0;
                run++;
                k++;
            end
            heap_free = (heap_free + run + 1 > COUNT_TOP) ? COUNT_TOP : heap_free + run + 1;
        end
        rsp.free_bytes = FREE_W'(heap_free);
    endtask

    function automatic t_case req_row(input logic op, input int unsigned size,
                                      input int unsigned addr, input bit typed = 1'b0,
                                      input logic st = ST_OK, input int unsigned start = 0,
                                      input int unsigned avail = 0);
        t_case c;
        c.req.op             = op;
        c.req.size           = SIZE_W'(size);
        c.req.address        = ADDR_W'(addr);
        c.typed              = typed;
        c.rsp.status         = st;
        c.rsp.start_res      = START_W'(start);
        c.rsp.free_bytes     = FREE_W'(avail);
        return c;
    endfunction

    task automatic send_req(input t_case c, output t_rsp rsp);
        int pct;
        pct = (idle_phase == 0) ? 22 : (idle_phase == 1) ? 53 : 0;
        while ($urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= c.req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        heap_apply(c.req, rsp);
        rsp_owed_q.push_back(c.typed ? c.rsp : rsp);
        @(negedge i_clk);
    endtask

    initial begin
        t_rsp        rsp;
        t_case       c;
        int unsigned sel;
        int unsigned idx;
        int          top_hits;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        heap_used   = '0;
        heap_free   = HEAP_BYTES;

        dir_q.push_back(req_row(OP_ALLOC, 0, 10'h3FF, 1'b1, ST_FAIL, 0, 1024));
        dir_q.push_back(req_row(OP_FREE, 10'h3FF, 0, 1'b1, ST_OK, 0, 1025));
        dir_q.push_back(req_row(OP_ALLOC, 1023, 0, 1'b1, ST_OK, 0, 1));
        dir_q.push_back(req_row(OP_ALLOC, 1, 0, 1'b1, ST_FAIL, 0, 1));
        dir_q.push_back(req_row(OP_FREE, 0, 1023, 1'b1, ST_OK, 0, 2));
        dir_q.push_back(req_row(OP_FREE, 0, 0, 1'b1, ST_OK, 0, 1026));
        dir_q.push_back(req_row(OP_ALLOC, 1, 0));
        dir_q.push_back(req_row(OP_ALLOC, 1, 10'h3FF));
        dir_q.push_back(req_row(OP_ALLOC, 1023, 0, 1'b1, ST_FAIL, 0, 1022));
        dir_q.push_back(req_row(OP_FREE, 0, 2));
        dir_q.push_back(req_row(OP_ALLOC, 10'h2AA, 10'h155));
        dir_q.push_back(req_row(OP_ALLOC, 10'h155, 10'h2AA));
        dir_q.push_back(req_row(OP_FREE, 0, 10'h155));
        dir_q.push_back(req_row(OP_FREE, 0, 10'h2AA));
        dir_q.push_back(req_row(OP_FREE, 10'h3FF, 0));
        dir_q.push_back(req_row(OP_ALLOC, 512, 0));
        dir_q.push_back(req_row(OP_FREE, 0, 1));
        dir_q.push_back(req_row(OP_ALLOC, 3, 10'h3FF));
        dir_q.push_back(req_row(OP_FREE, 0, 0));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[i]) send_req(dir_q[i], rsp);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) idle_phase = 1;
            else if (n == 2 * RANDOM_ITEMS / 3) idle_phase = 2;
            c.typed       = 1'b0;
            c.rsp         = '0;
            c.req.address = ADDR_W'($urandom_range(HEAP_BYTES - 1));
            c.req.size    = SIZE_W'($urandom_range(1023));
            sel = $urandom_range(99);
            if (sel < 45) begin
                c.req.op = OP_ALLOC;
                sel = $urandom_range(99);
                if (sel < 4) c.req.size = '0;
                else if (sel < 74) c.req.size = SIZE_W'($urandom_range(31, 1));
                else if (sel < 94) c.req.size = SIZE_W'($urandom_range(255, 32));
                else c.req.size = SIZE_W'($urandom_range(1023, 256));
            end else if (sel < 88 && live_q.size() != 0) begin
                c.req.op = OP_FREE;
                idx = $urandom_range(live_q.size() - 1);
                c.req.address = ADDR_W'(live_q[idx]);
                live_q.delete(idx);
            end else begin
                c.req.op = OP_FREE;
            end
            send_req(c, rsp);
            if (c.req.op == OP_ALLOC && rsp.status == ST_OK) live_q.push_back(32'(rsp.start_res));
        end

        // Release every live block, then free stray addresses until the count has been at its top on eight frees.
        c.typed  = 1'b0;
        c.rsp    = '0;
        c.req.op = OP_FREE;
        while (live_q.size() != 0) begin
            c.req.size    = SIZE_W'($urandom_range(1023));
            c.req.address = ADDR_W'(live_q.pop_front());
            send_req(c, rsp);
        end
        top_hits = 0;
        while (top_hits < 8) begin
            c.req.size    = SIZE_W'($urandom_range(1023));
            c.req.address = ADDR_W'($urandom_range(HEAP_BYTES - 1));
            send_req(c, rsp);
            if (heap_free == COUNT_TOP) top_hits++;
        end
        i_in_valid <= 1'b0;

        while (rsp_owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_bitmap_first_fit_allocator_unit passed");
        end else begin
            $display("tb_bitmap_first_fit_allocator_unit failed");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && results_seen >= 60) begin
            hold_done   <= 1'b1;
            hold_cycles <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else begin
            case (idle_phase)
                0: i_out_stall <= ($urandom_range(99) < 53);
                1: i_out_stall <= ($urandom_range(99) < 22);
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (rsp_owed_q.size() == 0) begin
                $error("unrequested result item: %p", o_out_item);
                fail_count++;
            end else begin
                want = rsp_owed_q.pop_front();
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                    fail_count++;
                end
                if (o_out_item.start_res !== want.start_res) begin
                    $error("start_res: expected %0d, got %0d",
                           want.start_res, o_out_item.start_res);
                    fail_count++;
                end
                if (o_out_item.free_bytes !== want.free_bytes) begin
                    $error("free_bytes: expected %0d, got %0d",
                           want.free_bytes, o_out_item.free_bytes);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_bitmap_first_fit_allocator_unit failed");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_ram.sv
hw/rtl/bffa_engine.sv
hw/rtl/bitmap_first_fit_allocator_unit.sv
test/tb_bitmap_first_fit_allocator_unit.sv
